@@ hdl/ttmc_pkg.sv @@
// shared types, constants and constant-divider helpers of the tick timebase
package ttmc_pkg;

    localparam int CmdW     = 2;
    localparam int LowW     = 16;
    localparam int ValueW   = 32;
    localparam int TickW    = 32;
    localparam int MptW     = 10;
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 10;

    // timer-clock count and its product with the millisecond numerator
    localparam int CountW  = TickW + LowW;
    localparam int ScaledW = CountW + 4;
    // fine milliseconds before truncation
    localparam int MsW     = 39;
    localparam int TopW    = ScaledW - 48;
    localparam int Q2W     = 7;

    localparam logic [3:0] MsNum = 4'd11;

    // divide by 13125: x < 2^30, exact with a 44-bit shift
    localparam int          DivMsXW     = 30;
    localparam int          DivMsRW     = 14;
    localparam int          DivMsShift  = 44;
    localparam logic [30:0] DivMsRecip  = 31'd1340357032;
    localparam logic [13:0] DivMsD      = 14'd13125;

    // divide by 1000: x < 2^26, exact with a 36-bit shift
    localparam int          DivSXW      = 26;
    localparam int          DivSRW      = 10;
    localparam int          DivSShift   = 36;
    localparam logic [26:0] DivSRecip   = 27'd68719477;
    localparam logic [9:0]  DivSD       = 10'd1000;

    typedef enum logic [CmdW-1:0] {
        CMD_TICK = 2'd0,
        CMD_MS   = 2'd1,
        CMD_SEC  = 2'd2,
        CMD_RAW  = 2'd3
    } cmd_t;

    localparam logic [CfgIdxW-1:0] CFG_FINE_MODE   = 4'd0;
    localparam logic [CfgIdxW-1:0] CFG_MS_PER_TICK = 4'd1;
    localparam logic [MptW-1:0]    MsPerTickRst    = 10'd55;

    typedef struct packed {
        logic            fine_mode;
        logic [MptW-1:0] ms_per_tick;
    } cfg_t;

    // values that ride along the pipeline untouched
    typedef struct packed {
        cmd_t              cmd;
        logic [ValueW-1:0] direct;
    } side_t;

    typedef struct packed {
        side_t              side;
        logic               fine_mode;
        logic [ScaledW-1:0] scaled;
        logic [ValueW-1:0]  coarse;
    } front_t;

    function automatic logic [15:0] div_ms_q(input logic [DivMsXW-1:0] x);
        logic [60:0] prod;
        prod = 61'(x) * 61'(DivMsRecip);
        return prod[DivMsShift+15:DivMsShift];
    endfunction

    function automatic logic [DivMsRW-1:0] div_ms_r(input logic [DivMsXW-1:0] x,
                                                    input logic [15:0] q);
        logic [DivMsXW-1:0] back;
        back = DivMsXW'(q) * DivMsXW'(DivMsD);
        return DivMsRW'(x - back);
    endfunction

    function automatic logic [15:0] div_s_q(input logic [DivSXW-1:0] x);
        logic [52:0] prod;
        prod = 53'(x) * 53'(DivSRecip);
        return prod[DivSShift+15:DivSShift];
    endfunction

    function automatic logic [DivSRW-1:0] div_s_r(input logic [DivSXW-1:0] x,
                                                  input logic [15:0] q);
        logic [DivSXW-1:0] back;
        back = DivSXW'(q) * DivSXW'(DivSD);
        return DivSRW'(x - back);
    endfunction

endpackage

@@ hdl/ttmc_cfg.sv @@
// configuration register file: fine mode and milliseconds per tick
module ttmc_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ttmc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [ttmc_pkg::CfgDataW-1:0] cfg_data,
    output ttmc_pkg::cfg_t                cfg
);
    import ttmc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FINE_MODE:   cfg_next.fine_mode   = cfg_data[0];
                CFG_MS_PER_TICK: cfg_next.ms_per_tick = cfg_data[MptW-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fine_mode   <= 1'b0;
            cfg_reg.ms_per_tick <= MsPerTickRst;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/ttmc_front.sv @@
// input register, tick counter and first arithmetic stage
module ttmc_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ttmc_pkg::CmdW-1:0]  in_cmd,
    input  logic [ttmc_pkg::LowW-1:0]  in_low,
    input  ttmc_pkg::cfg_t             cfg,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ttmc_pkg::front_t           out
);
    import ttmc_pkg::*;

    logic [TickW-1:0]  tick_reg;
    logic [TickW-1:0]  tick_next;

    logic              v0_reg;
    cmd_t              cmd0_reg;
    logic [LowW-1:0]   low0_reg;
    logic [TickW-1:0]  tick0_reg;
    cfg_t              cfg0_reg;

    logic              v1_reg;
    front_t            f1_reg;
    front_t            f1_next;

    logic              rdy0;
    logic              rdy1;
    logic              accept;
    cmd_t              cmd_in;

    logic [CountW-1:0]  count;
    logic [ScaledW-1:0] count_ext;
    logic [41:0]        coarse_full;

    assign rdy1      = !v1_reg || out_ready;
    assign rdy0      = !v0_reg || rdy1;
    assign in_ready  = rdy0;
    assign accept    = in_valid && rdy0;
    assign cmd_in    = cmd_t'(in_cmd);
    assign out_valid = v1_reg;
    assign out       = f1_reg;

    // a tick bumps the counter and the snapshot carries the new count
    assign tick_next = (cmd_in == CMD_TICK) ? tick_reg + 32'd1 : tick_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
        end else begin
            if (accept) begin
                tick_reg <= tick_next;
            end
            if (rdy0) begin
                v0_reg <= in_valid;
            end
            if (rdy1) begin
                v1_reg <= v0_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0) begin
            cmd0_reg  <= cmd_in;
            low0_reg  <= in_low;
            tick0_reg <= tick_next;
            cfg0_reg  <= cfg;
        end
    end

    // (65536 - low) mod 65536 is the two's complement of low
    assign count     = {tick0_reg, LowW'(16'd0 - low0_reg)};
    assign count_ext = ScaledW'(count);
    assign coarse_full = 42'(tick0_reg) * 42'(cfg0_reg.ms_per_tick);

    always_comb begin
        f1_next.side.cmd = cmd0_reg;
        if (cmd0_reg == CMD_TICK) begin
            f1_next.side.direct = tick0_reg;
        end else begin
            f1_next.side.direct = {tick0_reg[15:0], 16'd0} - ValueW'(low0_reg);
        end
        f1_next.fine_mode = cfg0_reg.fine_mode;
        // times eleven as eight plus two plus one
        f1_next.scaled    = (count_ext << 3) + (count_ext << 1) + count_ext;
        f1_next.coarse    = coarse_full[ValueW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            f1_reg <= f1_next;
        end
    end

    logic unused_mul;
    assign unused_mul = ^{coarse_full[41:ValueW], MsNum};

endmodule

@@ hdl/ttmc_scale.sv @@
// long division by 13125 and by 1000 in 16-bit digits, and result selection
module ttmc_scale (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ttmc_pkg::front_t             in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ttmc_pkg::ValueW-1:0]  out_value
);
    import ttmc_pkg::*;

    localparam int Stages = 8;

    logic [Stages-1:0] v_reg;
    logic [Stages:0]   rdy;

    // stage a: top quotient digit of the millisecond division
    logic [Q2W-1:0]    qa2_reg;
    logic [19:0]       xa2_reg;
    logic [31:0]       lo_a_reg;
    logic              fine_a_reg;
    logic [ValueW-1:0] coarse_a_reg;
    side_t             side_a_reg;

    // stage b: remainder joined with the next digit
    logic [Q2W-1:0]     qb2_reg;
    logic [DivMsXW-1:0] xb1_reg;
    logic [15:0]        db0_reg;
    logic               fine_b_reg;
    logic [ValueW-1:0]  coarse_b_reg;
    side_t              side_b_reg;

    // stage c: middle quotient digit
    logic [Q2W-1:0]     qc2_reg;
    logic [15:0]        qc1_reg;
    logic [DivMsXW-1:0] xc1_reg;
    logic [15:0]        dc0_reg;
    logic               fine_c_reg;
    logic [ValueW-1:0]  coarse_c_reg;
    side_t              side_c_reg;

    // stage d: last dividend digit
    logic [Q2W-1:0]     qd2_reg;
    logic [15:0]        qd1_reg;
    logic [DivMsXW-1:0] xd0_reg;
    logic               fine_d_reg;
    logic [ValueW-1:0]  coarse_d_reg;
    side_t              side_d_reg;

    // stage e: millisecond value, fine or coarse
    logic [MsW-1:0]     ve_reg;
    logic [MsW-1:0]     ve_next;
    side_t              side_e_reg;

    // stage f: upper quotient digit of the seconds division
    logic [15:0]        qf1_reg;
    logic [22:0]        xf1_reg;
    logic [15:0]        ef0_reg;
    logic [ValueW-1:0]  ms_f_reg;
    side_t              side_f_reg;

    // stage g: remainder joined with the low digit
    logic [15:0]        qg1_reg;
    logic [DivSXW-1:0]  xg0_reg;
    logic [ValueW-1:0]  ms_g_reg;
    side_t              side_g_reg;

    logic [ValueW-1:0]  value_reg;
    logic [ValueW-1:0]  value_next;

    always_comb begin
        rdy[Stages] = out_ready;
        for (int i = Stages - 1; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[Stages-1];
    assign out_value = value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < Stages; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            xa2_reg      <= {in.scaled[ScaledW-1:48], in.scaled[47:32]};
            qa2_reg      <= Q2W'(div_ms_q(DivMsXW'({in.scaled[ScaledW-1:48],
                                                    in.scaled[47:32]})));
            lo_a_reg     <= in.scaled[31:0];
            fine_a_reg   <= in.fine_mode;
            coarse_a_reg <= in.coarse;
            side_a_reg   <= in.side;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            qb2_reg      <= qa2_reg;
            xb1_reg      <= {div_ms_r(DivMsXW'(xa2_reg), 16'(qa2_reg)), lo_a_reg[31:16]};
            db0_reg      <= lo_a_reg[15:0];
            fine_b_reg   <= fine_a_reg;
            coarse_b_reg <= coarse_a_reg;
            side_b_reg   <= side_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            qc2_reg      <= qb2_reg;
            qc1_reg      <= div_ms_q(xb1_reg);
            xc1_reg      <= xb1_reg;
            dc0_reg      <= db0_reg;
            fine_c_reg   <= fine_b_reg;
            coarse_c_reg <= coarse_b_reg;
            side_c_reg   <= side_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            qd2_reg      <= qc2_reg;
            qd1_reg      <= qc1_reg;
            xd0_reg      <= {div_ms_r(xc1_reg, qc1_reg), dc0_reg};
            fine_d_reg   <= fine_c_reg;
            coarse_d_reg <= coarse_c_reg;
            side_d_reg   <= side_c_reg;
        end
    end

    // coarse values share the seconds division with the fine ones
    always_comb begin
        if (fine_d_reg) begin
            ve_next = {qd2_reg, qd1_reg, div_ms_q(xd0_reg)};
        end else begin
            ve_next = MsW'(coarse_d_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            ve_reg     <= ve_next;
            side_e_reg <= side_d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            xf1_reg    <= ve_reg[38:16];
            qf1_reg    <= div_s_q(DivSXW'(ve_reg[38:16]));
            ef0_reg    <= ve_reg[15:0];
            ms_f_reg   <= ve_reg[ValueW-1:0];
            side_f_reg <= side_e_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            qg1_reg    <= qf1_reg;
            xg0_reg    <= {div_s_r(DivSXW'(xf1_reg), qf1_reg), ef0_reg};
            ms_g_reg   <= ms_f_reg;
            side_g_reg <= side_f_reg;
        end
    end

    always_comb begin
        case (side_g_reg.cmd)
            CMD_MS:  value_next = ms_g_reg;
            CMD_SEC: value_next = {qg1_reg, div_s_q(xg0_reg)};
            default: value_next = side_g_reg.direct;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            value_reg <= value_next;
        end
    end

endmodule

@@ hdl/tick_timebase_ms_converter.sv @@
// top level of the tick timebase with millisecond, second and raw readout
//
// Input stream: s_tuser carries the command (tick, read milliseconds, read
// seconds, read raw counts), s_tdata the sampled 16-bit interval-timer
// down-counter, which only reads use. Every request gives exactly one result
// on the output stream: m_tdata is the 32-bit value, for a tick the new tick
// count. The configuration channel writes fine mode (index 0) and
// milliseconds per tick (index 1); other indexes are ignored.
//
// A request reaches m_tvalid through ten register stages: an input
// register, one stage forming the timer-clock count times eleven, five
// stages of digit-wise division by 13125 (the last also picking the fine or
// coarse millisecond value) and three stages dividing by 1000, the last being
// the output register. One request is accepted per cycle while a stage is
// empty or the receiver takes a result.
// Reset clears the tick counter, selects coarse mode at 55 ms per tick and
// empties the pipeline. When the receiver stalls, the pipeline keeps filling
// its empty stages and s_tready drops only when every stage holds a request.
module tick_timebase_ms_converter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ttmc_pkg::LowW-1:0]     s_tdata,   // [15:0] counter_low
    input  logic [ttmc_pkg::CmdW-1:0]     s_tuser,   // [1:0] command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ttmc_pkg::ValueW-1:0]   m_tdata,   // [31:0] value
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ttmc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [ttmc_pkg::CfgDataW-1:0] cfg_data
);
    import ttmc_pkg::*;

    cfg_t   cfg;
    front_t front;
    logic   front_valid;
    logic   front_ready;

    ttmc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ttmc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_low    (s_tdata),
        .cfg       (cfg),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out       (front)
    );

    ttmc_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in        (front),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (m_tdata)
    );

endmodule

@@ tb/tb_tick_timebase_ms_converter.sv @@
// self-checking testbench of the tick timebase with millisecond, second and raw readout
module tb_tick_timebase_ms_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import ttmc_pkg::*;

    localparam logic [63:0] MsNumer  = 64'd11;
    localparam logic [63:0] MsDenom  = 64'd13125;
    localparam logic [63:0] MsPerSec = 64'd1000;

    // indexes past the register list, writes there must change nothing
    localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 4'd5;
    localparam logic [CfgIdxW-1:0] CfgTopIdx    = 4'hF;

    localparam int DrainCycles  = 14;
    localparam int PhaseCount   = 6;
    localparam int PhaseItems   = 225;

    class timebase_scoreboard;
        logic [TickW-1:0]  tick_count;
        logic              fine_mode;
        logic [MptW-1:0]   ms_per_tick;
        logic [ValueW-1:0] pending_values[$];
        int unsigned       failures;
        int unsigned       requests;
        int unsigned       results;

        function new();
            tick_count  = '0;
            fine_mode   = 1'b0;
            ms_per_tick = MsPerTickRst;
            failures    = 0;
            requests    = 0;
            results     = 0;
        endfunction

        function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            if (idx == CFG_FINE_MODE) begin
                fine_mode = data[0];
            end else if (idx == CFG_MS_PER_TICK) begin
                ms_per_tick = data[MptW-1:0];
            end
        endfunction

        // timer-clock count scaled to milliseconds, before truncation
        function logic [63:0] fine_millis(logic [LowW-1:0] low);
            logic [63:0] counts;
            counts = {16'd0, tick_count, LowW'(17'h10000 - {1'b0, low})};
            return (counts * MsNumer) / MsDenom;
        endfunction

        function void note_request(cmd_t cmd, logic [LowW-1:0] low);
            logic [ValueW-1:0] value;
            logic [ValueW-1:0] coarse_ms;
            coarse_ms = tick_count * ValueW'(ms_per_tick);
            case (cmd)
                CMD_TICK: begin
                    tick_count = tick_count + TickW'(1);
                    value = tick_count;
                end
                CMD_MS: begin
                    value = fine_mode ? ValueW'(fine_millis(low)) : coarse_ms;
                end
                CMD_SEC: begin
                    value = fine_mode ? ValueW'(fine_millis(low) / MsPerSec)
                                      : ValueW'({32'd0, coarse_ms} / MsPerSec);
                end
                default: begin
                    value = {tick_count[15:0], 16'd0} - ValueW'(low);
                end
            endcase
            pending_values.push_back(value);
            requests++;
        endfunction

        function void check_value(logic [ValueW-1:0] got);
            logic [ValueW-1:0] want;
            if (pending_values.size() == 0) begin
                $error("value: no result expected, got %h", got);
                failures++;
            end else begin
                want = pending_values.pop_front();
                results++;
                if (got !== want) begin
                    $error("value: expected %h, got %h", want, got);
                    failures++;
                end
            end
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [LowW-1:0]     s_tdata   = '0;   // [15:0] counter_low
    logic [CmdW-1:0]     s_tuser   = '0;   // [1:0] command
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [ValueW-1:0]   m_tdata;          // [31:0] value
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;

    timebase_scoreboard board;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    tick_timebase_ms_converter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: values sampled as they stood before the edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_value(m_tdata);
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(cmd_t cmd, logic [LowW-1:0] low);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= low;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(cmd, low);
    endtask

    task automatic send_random_request();
        cmd_t            cmd;
        logic [LowW-1:0] low;
        // ticks a little more often so the counter keeps climbing
        cmd = ($urandom_range(2) == 0) ? CMD_TICK : cmd_t'($urandom_range(3));
        case ($urandom_range(7))
            0:       low = '0;
            1:       low = '1;
            2:       low = LowW'(1);
            default: low = LowW'($urandom_range(16'hFFFF));
        endcase
        send_request(cmd, low);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_values.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        #5ms;
        $display("tick_timebase_ms_converter regression: fail");
        $finish;
    end

    initial begin
        logic [MptW-1:0] phase_mpt[PhaseCount]   = '{10'd55, 10'd1, 10'd1000, 10'd1023,
                                                     10'd0, 10'd1023};
        logic            phase_fine[PhaseCount]  = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
        int              phase_idle[PhaseCount]  = '{0, 78, 0, 36, 0, 36};
        int              phase_stall[PhaseCount] = '{0, 0, 78, 36, 0, 36};

        board = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // coarse mode at the reset rate, before any register write
        send_request(CMD_MS, '0);
        send_request(CMD_SEC, '0);
        send_request(CMD_RAW, '0);
        send_request(CMD_RAW, '1);
        send_request(CMD_TICK, '1);
        send_request(CMD_TICK, '0);
        send_request(CMD_MS, '1);
        send_request(CMD_SEC, 16'h8000);
        send_request(CMD_RAW, 16'd1);
        drain();

        // only bit 0 of the data counts for the mode, stray indexes do nothing
        cfg_write(CFG_FINE_MODE, 10'h3FF);
        cfg_write(CfgUnusedIdx, 10'h3FF);
        cfg_write(CfgTopIdx, '0);
        send_request(CMD_MS, '0);
        send_request(CMD_MS, 16'd1);
        send_request(CMD_MS, '1);
        send_request(CMD_MS, 16'h8000);
        send_request(CMD_SEC, 16'd1);
        send_request(CMD_RAW, 16'h8000);
        send_request(CMD_TICK, 16'h5555);
        send_request(CMD_TICK, 16'hAAAA);
        send_request(CMD_SEC, '0);
        send_request(CMD_MS, '1);
        drain();

        cfg_write(CFG_FINE_MODE, 10'h3FE);
        cfg_write(CFG_MS_PER_TICK, 10'h3FF);
        send_request(CMD_MS, '0);
        send_request(CMD_SEC, '1);
        drain();

        for (int p = 0; p < PhaseCount; p++) begin
            cfg_write(CFG_FINE_MODE, {9'd0, phase_fine[p]});
            cfg_write(CFG_MS_PER_TICK, phase_mpt[p]);
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (int i = 0; i < PhaseItems; i++) begin
                // hold the sender back until the pipeline is empty
                if (p == 1 && i == PhaseItems / 2) begin
                    drain();
                end
                send_random_request();
            end
            drain();
        end

        if (board.pending_values.size() != 0) begin
            $error("value: %0d expected results never arrived", board.pending_values.size());
            board.failures++;
        end
        $display("%0d requests over %0d idle/stall phases, %0d results compared, final tick %0d",
                 board.requests, PhaseCount + 1, board.results, board.tick_count);
        $display("coarse and fine modes, rates 0 to 1023 ms per tick, down-counter extremes");
        if (board.failures == 0) begin
            $display("tick_timebase_ms_converter regression: pass");
        end else begin
            $display("tick_timebase_ms_converter regression: fail");
        end
        $finish;
    end

endmodule
